// ===== sv/pip_pkg.sv =====
// shared types and constants of the even-odd point-in-polygon block
// no dependencies
package pip_pkg;

    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // register index taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed
    {
        logic              valid;
        logic              query;
        logic [SLOT_W-1:0] slot;
        logic              toggle;
    } token_ctrl_t;

endpackage

// ===== sv/point_in_polygon_even_odd_top.sv =====
// top level of the even-odd point-in-polygon block: cell chain, closing edge,
// output register and configuration port; depends on pip_pkg, pip_cell, pip_cross
//
// Input channel (in_valid/in_stall) takes one word per cycle: command 0 writes
// coord_x/coord_y into ring slot vertex_slot, command 1 queries a point.
// Only queries give an output word (out_valid/out_stall) carrying inside_res.
// The word travels a chain of MAX_VERTICES cells, two register stages each,
// every cell holding one vertex, all but cell 0 testing the edge into it; the
// closing edge from the last vertex back to vertex 0 takes two more stages.
// Throughput: one word per cycle while in_stall is low, loads and queries
// mixed in any order; a load reaches its cell ahead of every later query, so
// ordering is kept. vertex_count is set through the APB port when paddr[2]
// is 0; the user must write it only while idle, which the block itself does
// not enforce. When out_stall holds a waiting result the whole chain freezes
// and in_stall is raised; otherwise words keep flowing.
// Reset clears vertex_count and all word valid flags; the vertex store holds
// no reset value and must be written before a query uses it.
module point_in_polygon_even_odd_top #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [pip_pkg::SLOT_W-1:0]   vertex_slot,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         inside_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import pip_pkg::*;

    localparam int CNT_W = ($clog2(MAX_VERTICES + 1) > COUNT_W) ?
                           $clog2(MAX_VERTICES + 1) : COUNT_W;

    logic [COUNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0]   n;
    logic               n3;
    logic               advance;

    token_ctrl_t                  ctrl_w    [0:MAX_VERTICES];
    logic signed [COORD_BITS-1:0] px_w      [0:MAX_VERTICES];
    logic signed [COORD_BITS-1:0] py_w      [0:MAX_VERTICES];
    logic signed [COORD_BITS-1:0] prev_x_w  [0:MAX_VERTICES];
    logic signed [COORD_BITS-1:0] prev_y_w  [0:MAX_VERTICES];
    logic signed [COORD_BITS-1:0] first_x_w [0:MAX_VERTICES];
    logic signed [COORD_BITS-1:0] first_y_w [0:MAX_VERTICES];

    token_ctrl_t ctrl_c_reg;
    logic        cross_c;
    logic        out_valid_reg;
    logic        inside_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT))
        begin
            vertex_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign n  = (CNT_W'(vertex_count_reg) > CNT_W'(MAX_VERTICES)) ?
                CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count_reg);
    assign n3 = n >= CNT_W'(3);

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // chain head
    always_comb
    begin
        ctrl_w[0].valid  = in_valid;
        ctrl_w[0].query  = (cmd_t'(command) == CMD_QUERY);
        ctrl_w[0].slot   = vertex_slot;
        ctrl_w[0].toggle = 1'b0;
    end

    assign px_w[0]      = coord_x;
    assign py_w[0]      = coord_y;
    assign prev_x_w[0]  = coord_x;
    assign prev_y_w[0]  = coord_y;
    assign first_x_w[0] = coord_x;
    assign first_y_w[0] = coord_y;

    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        pip_cell #(
            .COORD_BITS(COORD_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (advance),
            .n          (n),
            .ctrl_in    (ctrl_w[i]),
            .px_in      (px_w[i]),
            .py_in      (py_w[i]),
            .prev_x_in  (prev_x_w[i]),
            .prev_y_in  (prev_y_w[i]),
            .first_x_in (first_x_w[i]),
            .first_y_in (first_y_w[i]),
            .ctrl_out   (ctrl_w[i+1]),
            .px_out     (px_w[i+1]),
            .py_out     (py_w[i+1]),
            .prev_x_out (prev_x_w[i+1]),
            .prev_y_out (prev_y_w[i+1]),
            .first_x_out(first_x_w[i+1]),
            .first_y_out(first_y_w[i+1])
        );
    end

    // closing edge: last vertex back to vertex 0
    pip_cross #(
        .COORD_BITS(COORD_BITS)
    ) u_close (
        .clk  (clk),
        .en   (advance),
        .ax   (prev_x_w[MAX_VERTICES]),
        .ay   (prev_y_w[MAX_VERTICES]),
        .bx   (first_x_w[MAX_VERTICES]),
        .by   (first_y_w[MAX_VERTICES]),
        .px   (px_w[MAX_VERTICES]),
        .py   (py_w[MAX_VERTICES]),
        .hit  (cross_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_c_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            ctrl_c_reg    <= ctrl_w[MAX_VERTICES];
            out_valid_reg <= ctrl_c_reg.valid && ctrl_c_reg.query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inside_reg <= n3 && (ctrl_c_reg.toggle ^ cross_c);
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

`ifndef SYNTHESIS
    a_inside_needs_three : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> n3)
        else $error("inside flag with fewer than three vertices");

    a_rise_after_advance : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("result appeared while the chain was frozen");

    a_stall_only_on_hold : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");
`endif

endmodule

// ===== sv/pip_cross.sv =====
// exact edge crossing test: registered products, then compare
// depends on nothing but its parameter
module pip_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output logic                         hit
);

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;

    logic signed [D-1:0] dpx;
    logic signed [D-1:0] dbx;
    logic signed [D-1:0] dpy;
    logic signed [D-1:0] dy;
    logic signed [P-1:0] left_next;
    logic signed [P-1:0] right_next;
    logic                straddle_next;
    logic                dypos_next;

    logic signed [P-1:0] left_reg;
    logic signed [P-1:0] right_reg;
    logic                straddle_reg;
    logic                dypos_reg;

    assign dpx = D'(px) - D'(ax);
    assign dbx = D'(bx) - D'(ax);
    assign dpy = D'(py) - D'(ay);
    assign dy  = D'(by) - D'(ay);

    assign left_next     = P'(dpx) * P'(dy);
    assign right_next    = P'(dbx) * P'(dpy);
    assign straddle_next = (ay > py) != (by > py);
    assign dypos_next    = by > ay;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg     <= left_next;
            right_reg    <= right_next;
            straddle_reg <= straddle_next;
            dypos_reg    <= dypos_next;
        end
    end

    assign hit = straddle_reg &&
                 (dypos_reg ? (left_reg < right_reg) : (right_reg < left_reg));

endmodule

// ===== sv/pip_cell.sv =====
// one chain cell: holds one outline vertex and, in all but cell 0, tests the edge ending at it
// depends on pip_pkg and pip_cross
module pip_cell #(
    parameter int COORD_BITS = 16,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [CNT_W-1:0]             n,
    input  pip_pkg::token_ctrl_t         ctrl_in,
    input  logic signed [COORD_BITS-1:0] px_in,
    input  logic signed [COORD_BITS-1:0] py_in,
    input  logic signed [COORD_BITS-1:0] prev_x_in,
    input  logic signed [COORD_BITS-1:0] prev_y_in,
    input  logic signed [COORD_BITS-1:0] first_x_in,
    input  logic signed [COORD_BITS-1:0] first_y_in,
    output pip_pkg::token_ctrl_t         ctrl_out,
    output logic signed [COORD_BITS-1:0] px_out,
    output logic signed [COORD_BITS-1:0] py_out,
    output logic signed [COORD_BITS-1:0] prev_x_out,
    output logic signed [COORD_BITS-1:0] prev_y_out,
    output logic signed [COORD_BITS-1:0] first_x_out,
    output logic signed [COORD_BITS-1:0] first_y_out
);

    import pip_pkg::*;

    localparam logic IS_FIRST = (INDEX == 0);

    logic signed [COORD_BITS-1:0] vx_reg;
    logic signed [COORD_BITS-1:0] vy_reg;

    token_ctrl_t                  ctrl1_reg;
    logic                         test1_reg;
    logic signed [COORD_BITS-1:0] px1_reg;
    logic signed [COORD_BITS-1:0] py1_reg;
    logic signed [COORD_BITS-1:0] prev_x1_reg;
    logic signed [COORD_BITS-1:0] prev_y1_reg;
    logic signed [COORD_BITS-1:0] first_x1_reg;
    logic signed [COORD_BITS-1:0] first_y1_reg;

    token_ctrl_t                  ctrl2_reg;
    token_ctrl_t                  ctrl2_next;
    logic signed [COORD_BITS-1:0] px2_reg;
    logic signed [COORD_BITS-1:0] py2_reg;
    logic signed [COORD_BITS-1:0] prev_x2_reg;
    logic signed [COORD_BITS-1:0] prev_y2_reg;
    logic signed [COORD_BITS-1:0] first_x2_reg;
    logic signed [COORD_BITS-1:0] first_y2_reg;

    logic active;
    logic is_query;
    logic take;
    logic load_hit;
    logic edge_hit;

    assign active   = CNT_W'(INDEX) < n;
    assign is_query = ctrl_in.valid && ctrl_in.query;
    assign take     = is_query && active;
    assign load_hit = ctrl_in.valid && !ctrl_in.query &&
                      (CNT_W'(ctrl_in.slot) == CNT_W'(INDEX));

    pip_cross #(
        .COORD_BITS(COORD_BITS)
    ) u_cross (
        .clk  (clk),
        .en   (en),
        .ax   (prev_x_in),
        .ay   (prev_y_in),
        .bx   (vx_reg),
        .by   (vy_reg),
        .px   (px_in),
        .py   (py_in),
        .hit  (edge_hit)
    );

    // vertex store of this cell
    always_ff @(posedge clk)
    begin
        if (en && load_hit)
        begin
            vx_reg <= px_in;
            vy_reg <= py_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end
        else if (en)
        begin
            ctrl1_reg <= ctrl_in;
            ctrl2_reg <= ctrl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            test1_reg    <= take && !IS_FIRST;
            px1_reg      <= px_in;
            py1_reg      <= py_in;
            prev_x1_reg  <= take ? vx_reg : prev_x_in;
            prev_y1_reg  <= take ? vy_reg : prev_y_in;
            first_x1_reg <= (take && IS_FIRST) ? vx_reg : first_x_in;
            first_y1_reg <= (take && IS_FIRST) ? vy_reg : first_y_in;
            px2_reg      <= px1_reg;
            py2_reg      <= py1_reg;
            prev_x2_reg  <= prev_x1_reg;
            prev_y2_reg  <= prev_y1_reg;
            first_x2_reg <= first_x1_reg;
            first_y2_reg <= first_y1_reg;
        end
    end

    always_comb
    begin
        ctrl2_next        = ctrl1_reg;
        ctrl2_next.toggle = ctrl1_reg.toggle ^ (test1_reg && edge_hit);
    end

    assign ctrl_out    = ctrl2_reg;
    assign px_out      = px2_reg;
    assign py_out      = py2_reg;
    assign prev_x_out  = prev_x2_reg;
    assign prev_y_out  = prev_y2_reg;
    assign first_x_out = first_x2_reg;
    assign first_y_out = first_y2_reg;

endmodule
